// ===== rtl/htac_pkg.sv =====
// shared types, constants and helper functions of the hit-triggered actuator controller
package htac_pkg;

  // word kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_EDGE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_RAMP_DOWN_STEP   = 3'd0;
  localparam logic [2:0] CFG_RAMP_UP_STEP     = 3'd1;
  localparam logic [2:0] CFG_HOLD_LEVEL       = 3'd2;
  localparam logic [2:0] CFG_RAMP_INTERVAL_MS = 3'd3;
  localparam logic [2:0] CFG_FULL_SPEED_MS    = 3'd4;
  localparam logic [2:0] CFG_RETURN_WAIT_MS   = 3'd5;
  localparam logic [2:0] CFG_LINK_TIMEOUT_MS  = 3'd6;

  // configuration reset values
  localparam logic [7:0]  RST_RAMP_DOWN_STEP   = 8'd5;
  localparam logic [7:0]  RST_RAMP_UP_STEP     = 8'd5;
  localparam logic [7:0]  RST_HOLD_LEVEL       = 8'd150;
  localparam logic [7:0]  RST_RAMP_INTERVAL_MS = 8'd5;
  localparam logic [15:0] RST_FULL_SPEED_MS    = 16'd800;
  localparam logic [15:0] RST_RETURN_WAIT_MS   = 16'd1500;
  localparam logic [15:0] RST_LINK_TIMEOUT_MS  = 16'd3000;

  // misc constants
  localparam logic [7:0]  LEVEL_STOP   = 8'd255;
  localparam logic [7:0]  MANUAL_NONE  = 8'd255;
  localparam logic [7:0]  GAIN_MAX     = 8'd254;
  localparam logic [7:0]  GAIN_RESET   = 8'd62;
  localparam logic [7:0]  MODE_AUTO    = 8'd0;
  localparam logic [7:0]  MODE_UP      = 8'd1;
  localparam logic [7:0]  MODE_DOWN    = 8'd2;
  localparam logic [15:0] MS_MAX       = 16'hFFFF;
  localparam logic [7:0]  HITS_MAX     = 8'hFF;
  localparam logic [1:0]  CH_NONE      = 2'd0;
  localparam logic [1:0]  CH_CRITICAL  = 2'd1;
  localparam logic        DIR_LOWER    = 1'b0;
  localparam logic        DIR_UP       = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ACCEL = 3'd1,
    PH_FULL  = 3'd2,
    PH_EASE  = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_DOWN = 2'd1,
    TGT_UP   = 2'd2
  } target_t;

  typedef struct packed {
    logic [7:0]  ramp_down_step;
    logic [7:0]  ramp_up_step;
    logic [7:0]  hold_level;
    logic [7:0]  ramp_interval_ms;
    logic [15:0] full_speed_ms;
    logic [15:0] return_wait_ms;
    logic [15:0] link_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       control_on;
    logic [7:0] mode;
    logic [2:0] ban_mask;
    logic [7:0] gain_request;
    logic [7:0] critical_needed;
    logic [7:0] noncritical_needed;
    logic [1:0] detect_channel;
    logic       top_switch;
    logic       under_switch;
  } item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_channel;
    logic [7:0] motor_level;
    logic       motor_dir;
    logic [7:0] gain_level;
    logic [2:0] motor_phase;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] level;
    logic       dir;
    logic       timer_running;
    target_t    target;
  } motor_t;

  // start a move: full stop level, accelerate phase, timer restarted by caller
  function automatic motor_t motor_drive(input motor_t m, input logic down);
    motor_t r;
    r               = m;
    r.dir           = down ? DIR_LOWER : DIR_UP;
    r.target        = down ? TGT_DOWN : TGT_UP;
    r.level         = LEVEL_STOP;
    r.phase         = PH_ACCEL;
    r.timer_running = 1'b1;
    return r;
  endfunction

  function automatic motor_t motor_halt(input motor_t m);
    motor_t r;
    r               = m;
    r.level         = LEVEL_STOP;
    r.timer_running = 1'b0;
    r.phase         = PH_IDLE;
    r.target        = TGT_NONE;
    return r;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == MS_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == HITS_MAX) ? v : v + 8'd1;
  endfunction

  // ban bit for a detector channel, channel none is never banned
  function automatic logic ch_banned(input logic [2:0] bans, input logic [1:0] ch);
    logic b;
    case (ch)
      2'd1:    b = bans[0];
      2'd2:    b = bans[1];
      2'd3:    b = bans[2];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/htac_cfg.sv =====
// configuration register file of the hit-triggered actuator controller
module htac_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output htac_pkg::cfg_t      cfg
);

  htac_pkg::cfg_t cfg_r;
  htac_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        htac_pkg::CFG_RAMP_DOWN_STEP:   cfg_nxt.ramp_down_step   = cfg_wdata[7:0];
        htac_pkg::CFG_RAMP_UP_STEP:     cfg_nxt.ramp_up_step     = cfg_wdata[7:0];
        htac_pkg::CFG_HOLD_LEVEL:       cfg_nxt.hold_level       = cfg_wdata[7:0];
        htac_pkg::CFG_RAMP_INTERVAL_MS: cfg_nxt.ramp_interval_ms = cfg_wdata[7:0];
        htac_pkg::CFG_FULL_SPEED_MS:    cfg_nxt.full_speed_ms    = cfg_wdata;
        htac_pkg::CFG_RETURN_WAIT_MS:   cfg_nxt.return_wait_ms   = cfg_wdata;
        htac_pkg::CFG_LINK_TIMEOUT_MS:  cfg_nxt.link_timeout_ms  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_down_step   <= htac_pkg::RST_RAMP_DOWN_STEP;
      cfg_r.ramp_up_step     <= htac_pkg::RST_RAMP_UP_STEP;
      cfg_r.hold_level       <= htac_pkg::RST_HOLD_LEVEL;
      cfg_r.ramp_interval_ms <= htac_pkg::RST_RAMP_INTERVAL_MS;
      cfg_r.full_speed_ms    <= htac_pkg::RST_FULL_SPEED_MS;
      cfg_r.return_wait_ms   <= htac_pkg::RST_RETURN_WAIT_MS;
      cfg_r.link_timeout_ms  <= htac_pkg::RST_LINK_TIMEOUT_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/htac_core.sv =====
// controller state and single-pass update for one word
module htac_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  htac_pkg::item_t      item,
  input  htac_pkg::cfg_t       cfg,
  output htac_pkg::result_t    result
);

  logic              enabled_r, enabled_nxt;
  logic [7:0]        last_mode_r, last_mode_nxt;
  logic [7:0]        last_manual_r, last_manual_nxt;
  logic [2:0]        ban_bits_r, ban_bits_nxt;
  htac_pkg::motor_t  motor_r, motor_nxt;
  logic [15:0]       phase_ms_r, phase_ms_nxt;
  logic              return_pending_r, return_pending_nxt;
  logic [15:0]       return_ms_r, return_ms_nxt;
  logic [1:0]        pending_ch_r, pending_ch_nxt;
  logic [1:0]        reported_ch_r, reported_ch_nxt;
  logic [7:0]        crit_hits_r, crit_hits_nxt;
  logic [7:0]        noncrit_hits_r, noncrit_hits_nxt;
  logic [7:0]        crit_limit_r, crit_limit_nxt;
  logic [7:0]        noncrit_limit_r, noncrit_limit_nxt;
  logic [7:0]        gain_r, gain_nxt;
  logic [15:0]       link_ms_r, link_ms_nxt;
  logic              recover_raise_r, recover_raise_nxt;

  logic [8:0]        ease_sum;
  logic              crit_ready;
  logic              noncrit_ready;
  logic [15:0]       interval_ms;

  assign interval_ms = {8'd0, cfg.ramp_interval_ms};

  always_comb begin
    enabled_nxt        = enabled_r;
    last_mode_nxt      = last_mode_r;
    last_manual_nxt    = last_manual_r;
    ban_bits_nxt       = ban_bits_r;
    motor_nxt          = motor_r;
    phase_ms_nxt       = phase_ms_r;
    return_pending_nxt = return_pending_r;
    return_ms_nxt      = return_ms_r;
    pending_ch_nxt     = pending_ch_r;
    reported_ch_nxt    = reported_ch_r;
    crit_hits_nxt      = crit_hits_r;
    noncrit_hits_nxt   = noncrit_hits_r;
    crit_limit_nxt     = crit_limit_r;
    noncrit_limit_nxt  = noncrit_limit_r;
    gain_nxt           = gain_r;
    link_ms_nxt        = link_ms_r;
    recover_raise_nxt  = recover_raise_r;
    ease_sum           = 9'd0;
    crit_ready         = 1'b0;
    noncrit_ready      = 1'b0;

    case (item.op)
      htac_pkg::OP_TICK: begin
        link_ms_nxt   = htac_pkg::sat_inc16(link_ms_r);
        phase_ms_nxt  = htac_pkg::sat_inc16(phase_ms_r);
        return_ms_nxt = htac_pkg::sat_inc16(return_ms_r);

        // link lost
        if (link_ms_nxt >= cfg.link_timeout_ms) begin
          last_manual_nxt    = htac_pkg::MANUAL_NONE;
          motor_nxt          = htac_pkg::motor_halt(motor_nxt);
          pending_ch_nxt     = htac_pkg::CH_NONE;
          reported_ch_nxt    = htac_pkg::CH_NONE;
          crit_hits_nxt      = 8'd0;
          noncrit_hits_nxt   = 8'd0;
          return_pending_nxt = 1'b0;
          return_ms_nxt      = 16'd0;
          recover_raise_nxt  = 1'b1;
        end

        // motor profile
        if (motor_nxt.timer_running) begin
          if (motor_nxt.phase == htac_pkg::PH_ACCEL && phase_ms_nxt >= interval_ms) begin
            motor_nxt.level = (motor_nxt.level >= cfg.ramp_down_step) ?
                              motor_nxt.level - cfg.ramp_down_step : 8'd0;
            if (motor_nxt.level == 8'd0) begin
              motor_nxt.phase = htac_pkg::PH_FULL;
            end
            phase_ms_nxt = 16'd0;
          end else if (motor_nxt.phase == htac_pkg::PH_FULL &&
                       phase_ms_nxt >= cfg.full_speed_ms) begin
            motor_nxt.phase = htac_pkg::PH_EASE;
            phase_ms_nxt    = 16'd0;
          end else if (motor_nxt.phase == htac_pkg::PH_EASE &&
                       phase_ms_nxt >= interval_ms) begin
            ease_sum = {1'b0, motor_nxt.level} + {1'b0, cfg.ramp_up_step};
            if (ease_sum > {1'b0, cfg.hold_level}) begin
              ease_sum = {1'b0, cfg.hold_level};
            end
            motor_nxt.level = ease_sum[7:0];
            if (motor_nxt.level == cfg.hold_level) begin
              motor_nxt.phase         = htac_pkg::PH_HOLD;
              motor_nxt.timer_running = 1'b0;
            end else begin
              phase_ms_nxt = 16'd0;
            end
          end
        end

        // limit switches, upper one first
        if (!item.under_switch) begin
          if (motor_nxt.target == htac_pkg::TGT_UP) begin
            motor_nxt = htac_pkg::motor_halt(motor_nxt);
          end
        end else if (!item.top_switch) begin
          if (motor_nxt.target == htac_pkg::TGT_DOWN) begin
            motor_nxt = htac_pkg::motor_halt(motor_nxt);
            if (return_pending_nxt) begin
              return_ms_nxt = 16'd0;
            end
          end
        end

        // timed raise after reaching bottom
        if (return_pending_nxt && motor_nxt.phase == htac_pkg::PH_IDLE &&
            return_ms_nxt >= cfg.return_wait_ms) begin
          motor_nxt          = htac_pkg::motor_drive(motor_nxt, 1'b0);
          phase_ms_nxt       = 16'd0;
          pending_ch_nxt     = htac_pkg::CH_NONE;
          reported_ch_nxt    = htac_pkg::CH_NONE;
          return_pending_nxt = 1'b0;
        end
      end

      htac_pkg::OP_FRAME: begin
        last_mode_nxt = item.mode;
        link_ms_nxt   = 16'd0;
        if (!item.control_on) begin
          enabled_nxt        = 1'b0;
          last_manual_nxt    = htac_pkg::MANUAL_NONE;
          motor_nxt          = htac_pkg::motor_halt(motor_nxt);
          return_pending_nxt = 1'b0;
          return_ms_nxt      = 16'd0;
          pending_ch_nxt     = htac_pkg::CH_NONE;
          reported_ch_nxt    = htac_pkg::CH_NONE;
          crit_hits_nxt      = 8'd0;
          noncrit_hits_nxt   = 8'd0;
        end else begin
          enabled_nxt = 1'b1;
          if (recover_raise_r) begin
            return_pending_nxt = 1'b0;
            motor_nxt.phase    = htac_pkg::PH_IDLE;
            motor_nxt.target   = htac_pkg::TGT_NONE;
            if (item.under_switch) begin
              motor_nxt    = htac_pkg::motor_drive(motor_nxt, 1'b0);
              phase_ms_nxt = 16'd0;
            end
            recover_raise_nxt = 1'b0;
          end

          if (item.ban_mask != ban_bits_r) begin
            pending_ch_nxt  = htac_pkg::CH_NONE;
            reported_ch_nxt = htac_pkg::CH_NONE;
            ban_bits_nxt    = item.ban_mask;
          end
          gain_nxt          = (item.gain_request > htac_pkg::GAIN_MAX) ?
                              htac_pkg::GAIN_MAX : item.gain_request;
          crit_limit_nxt    = item.critical_needed;
          noncrit_limit_nxt = item.noncritical_needed;

          if (item.mode == htac_pkg::MODE_AUTO) begin
            crit_ready    = (crit_limit_nxt != 8'd0) && (crit_hits_nxt >= crit_limit_nxt);
            noncrit_ready = (noncrit_limit_nxt != 8'd0) &&
                            (noncrit_hits_nxt >= noncrit_limit_nxt);
            reported_ch_nxt = pending_ch_nxt;
            if (htac_pkg::ch_banned(ban_bits_nxt, reported_ch_nxt)) begin
              reported_ch_nxt = htac_pkg::CH_NONE;
              pending_ch_nxt  = htac_pkg::CH_NONE;
            end
            if (reported_ch_nxt != htac_pkg::CH_NONE &&
                motor_nxt.phase == htac_pkg::PH_IDLE && !return_pending_nxt &&
                (crit_ready || noncrit_ready)) begin
              motor_nxt          = htac_pkg::motor_drive(motor_nxt, 1'b1);
              phase_ms_nxt       = 16'd0;
              return_pending_nxt = 1'b1;
              crit_hits_nxt      = 8'd0;
              noncrit_hits_nxt   = 8'd0;
              pending_ch_nxt     = htac_pkg::CH_NONE;
            end
          end else begin
            return_pending_nxt = 1'b0;
            crit_hits_nxt      = 8'd0;
            noncrit_hits_nxt   = 8'd0;
            if (item.mode != last_manual_r) begin
              if (item.mode == htac_pkg::MODE_UP) begin
                motor_nxt    = htac_pkg::motor_drive(motor_nxt, 1'b0);
                phase_ms_nxt = 16'd0;
              end else if (item.mode == htac_pkg::MODE_DOWN) begin
                motor_nxt    = htac_pkg::motor_drive(motor_nxt, 1'b1);
                phase_ms_nxt = 16'd0;
              end
              last_manual_nxt = item.mode;
            end
          end
        end
      end

      htac_pkg::OP_EDGE: begin
        if (enabled_r && last_mode_r == htac_pkg::MODE_AUTO &&
            motor_r.phase == htac_pkg::PH_IDLE && !return_pending_r &&
            item.detect_channel != htac_pkg::CH_NONE &&
            !htac_pkg::ch_banned(ban_bits_r, item.detect_channel)) begin
          if (pending_ch_r == htac_pkg::CH_NONE) begin
            pending_ch_nxt = item.detect_channel;
          end
          if (item.detect_channel == htac_pkg::CH_CRITICAL) begin
            crit_hits_nxt = htac_pkg::sat_inc8(crit_hits_r);
          end else begin
            noncrit_hits_nxt = htac_pkg::sat_inc8(noncrit_hits_r);
          end
        end
      end

      default: ;
    endcase
  end

  always_comb begin
    result.reply_valid   = (item.op == htac_pkg::OP_FRAME);
    result.reply_channel = result.reply_valid ? reported_ch_nxt : htac_pkg::CH_NONE;
    result.motor_level   = motor_nxt.level;
    result.motor_dir     = motor_nxt.dir;
    result.gain_level    = gain_nxt;
    result.motor_phase   = motor_nxt.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r              <= 1'b0;
      last_mode_r            <= htac_pkg::MODE_AUTO;
      last_manual_r          <= htac_pkg::MANUAL_NONE;
      ban_bits_r             <= 3'd0;
      motor_r.phase          <= htac_pkg::PH_IDLE;
      motor_r.level          <= htac_pkg::LEVEL_STOP;
      motor_r.dir            <= htac_pkg::DIR_UP;
      motor_r.timer_running  <= 1'b0;
      motor_r.target         <= htac_pkg::TGT_NONE;
      phase_ms_r             <= 16'd0;
      return_pending_r       <= 1'b0;
      return_ms_r            <= 16'd0;
      pending_ch_r           <= htac_pkg::CH_NONE;
      reported_ch_r          <= htac_pkg::CH_NONE;
      crit_hits_r            <= 8'd0;
      noncrit_hits_r         <= 8'd0;
      crit_limit_r           <= 8'd0;
      noncrit_limit_r        <= 8'd0;
      gain_r                 <= htac_pkg::GAIN_RESET;
      link_ms_r              <= 16'd0;
      recover_raise_r        <= 1'b0;
    end else if (step_en) begin
      enabled_r        <= enabled_nxt;
      last_mode_r      <= last_mode_nxt;
      last_manual_r    <= last_manual_nxt;
      ban_bits_r       <= ban_bits_nxt;
      motor_r          <= motor_nxt;
      phase_ms_r       <= phase_ms_nxt;
      return_pending_r <= return_pending_nxt;
      return_ms_r      <= return_ms_nxt;
      pending_ch_r     <= pending_ch_nxt;
      reported_ch_r    <= reported_ch_nxt;
      crit_hits_r      <= crit_hits_nxt;
      noncrit_hits_r   <= noncrit_hits_nxt;
      crit_limit_r     <= crit_limit_nxt;
      noncrit_limit_r  <= noncrit_limit_nxt;
      gain_r           <= gain_nxt;
      link_ms_r        <= link_ms_nxt;
      recover_raise_r  <= recover_raise_nxt;
    end
  end

endmodule

// ===== rtl/hit_triggered_actuator_controller_top.sv =====
// top level of the hit-triggered actuator controller: input register, update, result register
//
// takes one word per clock while out_ready is high: a millisecond tick, a host command
// frame or a detector rising edge, and gives exactly one result word per input word
// (reply flag and channel, motor level and direction, sensor gain, motor phase). a
// word is captured in an input register, the controller state is updated from it in
// a single pass of short logic, and the result lands in an output register.
// sustained rate is one word per cycle while out_ready is high, set by the one
// update stage, and the input keeps accepting while a result waits on out_ready as
// long as the input register is free or moving. configuration writes on cfg_we are
// registered and must only be made while no word is in flight. no clearing pass
// after reset.
module hit_triggered_actuator_controller_top (
  input  logic        clk,
  input  logic        rst_n,

  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  // input word channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic        in_control_on,
  input  logic [7:0]  in_mode,
  input  logic [2:0]  in_ban_mask,
  input  logic [7:0]  in_gain_request,
  input  logic [7:0]  in_critical_needed,
  input  logic [7:0]  in_noncritical_needed,
  input  logic [1:0]  in_detect_channel,
  input  logic        in_top_switch,
  input  logic        in_under_switch,

  // result word channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reply_valid,
  output logic [1:0]  out_reply_channel,
  output logic [7:0]  out_motor_level,
  output logic        out_motor_dir,
  output logic [7:0]  out_gain_level,
  output logic [2:0]  out_motor_phase
);

  htac_pkg::cfg_t    cfg;
  htac_pkg::item_t   item_r;
  htac_pkg::item_t   item_nxt;
  htac_pkg::result_t result_nxt;
  htac_pkg::result_t result_r;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  htac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the held word moves on whenever the result register is empty or being drained
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    item_nxt.op                 = in_op;
    item_nxt.control_on         = in_control_on;
    item_nxt.mode               = in_mode;
    item_nxt.ban_mask           = in_ban_mask;
    item_nxt.gain_request       = in_gain_request;
    item_nxt.critical_needed    = in_critical_needed;
    item_nxt.noncritical_needed = in_noncritical_needed;
    item_nxt.detect_channel     = in_detect_channel;
    item_nxt.top_switch         = in_top_switch;
    item_nxt.under_switch       = in_under_switch;
  end

  // state update happens in the same cycle the result is captured
  htac_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result_nxt)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_valid   = result_r.reply_valid;
  assign out_reply_channel = result_r.reply_channel;
  assign out_motor_level   = result_r.motor_level;
  assign out_motor_dir     = result_r.motor_dir;
  assign out_gain_level    = result_r.gain_level;
  assign out_motor_phase   = result_r.motor_phase;

endmodule

// ===== bench/htac_status_checker.sv =====
// status checker: mirrors the controller state, predicts each result word and compares it
module htac_status_checker
  import htac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic        in_control_on,
  input  logic [7:0]  in_mode,
  input  logic [2:0]  in_ban_mask,
  input  logic [7:0]  in_gain_request,
  input  logic [7:0]  in_critical_needed,
  input  logic [7:0]  in_noncritical_needed,
  input  logic [1:0]  in_detect_channel,
  input  logic        in_top_switch,
  input  logic        in_under_switch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_reply_valid,
  input  logic [1:0]  out_reply_channel,
  input  logic [7:0]  out_motor_level,
  input  logic        out_motor_dir,
  input  logic [7:0]  out_gain_level,
  input  logic [2:0]  out_motor_phase,
  output int          fail_count,
  output int          pending
);

  cfg_t       regs;
  logic       enabled_q;
  logic [7:0] mode_q;
  logic [7:0] manual_q;
  logic [2:0] bans_q;
  phase_t     phase_q;
  logic [7:0] level_q;
  logic       dir_q;
  logic       timer_on;
  logic [15:0] phase_ms_q;
  target_t    target_q;
  logic       ret_pending;
  logic [15:0] ret_ms_q;
  logic [1:0] pend_ch;
  logic [1:0] rep_ch;
  logic [7:0] crit_hits;
  logic [7:0] non_hits;
  logic [7:0] crit_lim;
  logic [7:0] non_lim;
  logic [7:0] gain_q;
  logic [15:0] link_ms_q;
  logic       recover_q;

  result_t status_due[$];

  task automatic start_move(input logic down);
    dir_q      = down ? DIR_LOWER : DIR_UP;
    target_q   = down ? TGT_DOWN : TGT_UP;
    level_q    = LEVEL_STOP;
    phase_q    = PH_ACCEL;
    timer_on   = 1'b1;
    phase_ms_q = '0;
  endtask

  task automatic stop_motor();
    level_q  = LEVEL_STOP;
    timer_on = 1'b0;
    phase_q  = PH_IDLE;
    target_q = TGT_NONE;
  endtask

  task automatic clear_hits();
    pend_ch   = CH_NONE;
    rep_ch    = CH_NONE;
    crit_hits = '0;
    non_hits  = '0;
  endtask

  // one word in, new state and the status word it causes out
  task automatic predict_status(input item_t w, output result_t r);
    logic [8:0] eased;
    logic       cri_ok;
    logic       non_ok;
    case (w.op)
      OP_TICK: begin
        if (link_ms_q != MS_MAX) link_ms_q = link_ms_q + 16'd1;
        if (phase_ms_q != MS_MAX) phase_ms_q = phase_ms_q + 16'd1;
        if (ret_ms_q != MS_MAX) ret_ms_q = ret_ms_q + 16'd1;
        // link lost
        if (link_ms_q >= regs.link_timeout_ms) begin
          manual_q = MANUAL_NONE;
          stop_motor();
          clear_hits();
          ret_pending = 1'b0;
          ret_ms_q    = '0;
          recover_q   = 1'b1;
        end
        // motor profile
        if (timer_on) begin
          if (phase_q == PH_ACCEL && phase_ms_q >= {8'd0, regs.ramp_interval_ms}) begin
            level_q = (level_q >= regs.ramp_down_step) ? level_q - regs.ramp_down_step : 8'd0;
            if (level_q == 8'd0) phase_q = PH_FULL;
            phase_ms_q = '0;
          end else if (phase_q == PH_FULL && phase_ms_q >= regs.full_speed_ms) begin
            phase_q    = PH_EASE;
            phase_ms_q = '0;
          end else if (phase_q == PH_EASE && phase_ms_q >= {8'd0, regs.ramp_interval_ms}) begin
            eased = {1'b0, level_q} + {1'b0, regs.ramp_up_step};
            if (eased > {1'b0, regs.hold_level}) eased = {1'b0, regs.hold_level};
            level_q = eased[7:0];
            if (level_q == regs.hold_level) begin
              phase_q  = PH_HOLD;
              timer_on = 1'b0;
            end else begin
              phase_ms_q = '0;
            end
          end
        end
        // limit switches, upper one wins
        if (!w.under_switch) begin
          if (target_q == TGT_UP) stop_motor();
        end else if (!w.top_switch) begin
          if (target_q == TGT_DOWN) begin
            stop_motor();
            if (ret_pending) ret_ms_q = '0;
          end
        end
        if (ret_pending && phase_q == PH_IDLE && ret_ms_q >= regs.return_wait_ms) begin
          start_move(1'b0);
          pend_ch     = CH_NONE;
          rep_ch      = CH_NONE;
          ret_pending = 1'b0;
        end
      end
      OP_FRAME: begin
        mode_q    = w.mode;
        link_ms_q = '0;
        if (!w.control_on) begin
          enabled_q = 1'b0;
          manual_q  = MANUAL_NONE;
          stop_motor();
          ret_pending = 1'b0;
          ret_ms_q    = '0;
          clear_hits();
        end else begin
          enabled_q = 1'b1;
          if (recover_q) begin
            ret_pending = 1'b0;
            phase_q     = PH_IDLE;
            target_q    = TGT_NONE;
            if (w.under_switch) start_move(1'b0);
            recover_q = 1'b0;
          end
          if (w.ban_mask != bans_q) begin
            pend_ch = CH_NONE;
            rep_ch  = CH_NONE;
            bans_q  = w.ban_mask;
          end
          gain_q   = (w.gain_request > GAIN_MAX) ? GAIN_MAX : w.gain_request;
          crit_lim = w.critical_needed;
          non_lim  = w.noncritical_needed;
          if (w.mode == MODE_AUTO) begin
            cri_ok = crit_lim != 8'd0 && crit_hits >= crit_lim;
            non_ok = non_lim != 8'd0 && non_hits >= non_lim;
            rep_ch = pend_ch;
            if (rep_ch != CH_NONE && bans_q[rep_ch - 2'd1]) begin
              rep_ch  = CH_NONE;
              pend_ch = CH_NONE;
            end
            if (rep_ch != CH_NONE && phase_q == PH_IDLE && !ret_pending && (cri_ok || non_ok)) begin
              start_move(1'b1);
              ret_pending = 1'b1;
              crit_hits   = '0;
              non_hits    = '0;
              pend_ch     = CH_NONE;
            end
          end else begin
            ret_pending = 1'b0;
            crit_hits   = '0;
            non_hits    = '0;
            if (w.mode != manual_q) begin
              if (w.mode == MODE_UP) start_move(1'b0);
              else if (w.mode == MODE_DOWN) start_move(1'b1);
              manual_q = w.mode;
            end
          end
        end
      end
      OP_EDGE: begin
        if (enabled_q && mode_q == MODE_AUTO && phase_q == PH_IDLE && !ret_pending &&
            w.detect_channel != CH_NONE && !bans_q[w.detect_channel - 2'd1]) begin
          if (pend_ch == CH_NONE) pend_ch = w.detect_channel;
          if (w.detect_channel == CH_CRITICAL) begin
            if (crit_hits != HITS_MAX) crit_hits = crit_hits + 8'd1;
          end else begin
            if (non_hits != HITS_MAX) non_hits = non_hits + 8'd1;
          end
        end
      end
      default: ;
    endcase
    r.reply_valid   = (w.op == OP_FRAME);
    r.reply_channel = r.reply_valid ? rep_ch : CH_NONE;
    r.motor_level   = level_q;
    r.motor_dir     = dir_q;
    r.gain_level    = gain_q;
    r.motor_phase   = phase_q;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    item_t   w;
    result_t want;
    if (!rst_n) begin
      regs.ramp_down_step   = RST_RAMP_DOWN_STEP;
      regs.ramp_up_step     = RST_RAMP_UP_STEP;
      regs.hold_level       = RST_HOLD_LEVEL;
      regs.ramp_interval_ms = RST_RAMP_INTERVAL_MS;
      regs.full_speed_ms    = RST_FULL_SPEED_MS;
      regs.return_wait_ms   = RST_RETURN_WAIT_MS;
      regs.link_timeout_ms  = RST_LINK_TIMEOUT_MS;
      enabled_q   = 1'b0;
      mode_q      = MODE_AUTO;
      manual_q    = MANUAL_NONE;
      bans_q      = '0;
      phase_q     = PH_IDLE;
      level_q     = LEVEL_STOP;
      dir_q       = DIR_UP;
      timer_on    = 1'b0;
      phase_ms_q  = '0;
      target_q    = TGT_NONE;
      ret_pending = 1'b0;
      ret_ms_q    = '0;
      clear_hits();
      crit_lim    = '0;
      non_lim     = '0;
      gain_q      = GAIN_RESET;
      link_ms_q   = '0;
      recover_q   = 1'b0;
      fail_count  = 0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAMP_DOWN_STEP:   regs.ramp_down_step   = cfg_wdata[7:0];
          CFG_RAMP_UP_STEP:     regs.ramp_up_step     = cfg_wdata[7:0];
          CFG_HOLD_LEVEL:       regs.hold_level       = cfg_wdata[7:0];
          CFG_RAMP_INTERVAL_MS: regs.ramp_interval_ms = cfg_wdata[7:0];
          CFG_FULL_SPEED_MS:    regs.full_speed_ms    = cfg_wdata;
          CFG_RETURN_WAIT_MS:   regs.return_wait_ms   = cfg_wdata;
          CFG_LINK_TIMEOUT_MS:  regs.link_timeout_ms  = cfg_wdata;
          default: ;
        endcase
      end
      // results first: a word accepted at this edge cannot already be answered
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing predicted", $time);
        end else begin
          want = status_due.pop_front();
          check_field("reply_valid", 8'(want.reply_valid), 8'(out_reply_valid));
          check_field("reply_channel", 8'(want.reply_channel), 8'(out_reply_channel));
          check_field("motor_level", want.motor_level, out_motor_level);
          check_field("motor_dir", 8'(want.motor_dir), 8'(out_motor_dir));
          check_field("gain_level", want.gain_level, out_gain_level);
          check_field("motor_phase", 8'(want.motor_phase), 8'(out_motor_phase));
        end
      end
      if (in_valid && in_ready) begin
        w.op                 = in_op;
        w.control_on         = in_control_on;
        w.mode               = in_mode;
        w.ban_mask           = in_ban_mask;
        w.gain_request       = in_gain_request;
        w.critical_needed    = in_critical_needed;
        w.noncritical_needed = in_noncritical_needed;
        w.detect_channel     = in_detect_channel;
        w.top_switch         = in_top_switch;
        w.under_switch       = in_under_switch;
        predict_status(w, want);
        status_due.push_back(want);
      end
    end
    pending = status_due.size();
  end

endmodule

// ===== bench/hit_triggered_actuator_controller_top_tb.sv =====
// testbench top: clock, reset, word stimulus, receiver stalls and verdict
module hit_triggered_actuator_controller_top_tb;
  import htac_pkg::*;

  // unused word kind, answered with the current status
  localparam logic [1:0] OP_SPARE = 2'd3;
  // generous bound, several times the slowest legal run
  localparam int CYCLE_LIMIT = 1_000_000;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int HOLD_OFF_CYCLES = 80;

  typedef enum int {
    SET_DEFAULT,
    SET_MIN,
    SET_MAX,
    SET_ZERO,
    SET_RANDOM
  } setting_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic        in_control_on;
  logic [7:0]  in_mode;
  logic [2:0]  in_ban_mask;
  logic [7:0]  in_gain_request;
  logic [7:0]  in_critical_needed;
  logic [7:0]  in_noncritical_needed;
  logic [1:0]  in_detect_channel;
  logic        in_top_switch;
  logic        in_under_switch;
  logic        out_valid;
  logic        out_ready;
  logic        out_reply_valid;
  logic [1:0]  out_reply_channel;
  logic [7:0]  out_motor_level;
  logic        out_motor_dir;
  logic [7:0]  out_gain_level;
  logic [2:0]  out_motor_phase;
  int          fail_count;
  int          pending;

  // hold-off requests counted by the stimulus, served by the receiver process
  int          hold_off_req;
  int          cycles;

  hit_triggered_actuator_controller_top uut (.*);

  htac_status_checker checker_i (.*);

  // 8 time unit clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // idle lengths: mostly back to back, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random ready runs and stalls, plus the long hold-off on request
  initial begin
    int run_left;
    int served;
    out_ready = 1'b0;
    run_left  = 0;
    served    = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req != served) begin
        served = hold_off_req;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 1)) begin
        out_ready <= 1'b1;
        run_left = $urandom_range(0, 60);
      end else begin
        out_ready <= 1'b0;
        run_left = pick_gap();
      end
    end
  end

  // hold one word on the input until it is taken, leave at the next falling edge
  task automatic send_word(input item_t w);
    in_valid              <= 1'b1;
    in_op                 <= w.op;
    in_control_on         <= w.control_on;
    in_mode               <= w.mode;
    in_ban_mask           <= w.ban_mask;
    in_gain_request       <= w.gain_request;
    in_critical_needed    <= w.critical_needed;
    in_noncritical_needed <= w.noncritical_needed;
    in_detect_channel     <= w.detect_channel;
    in_top_switch         <= w.top_switch;
    in_under_switch       <= w.under_switch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // optional idle gap, then the word; valid only drops when a gap follows
  task automatic offer_word(input item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    send_word(w);
  endtask

  function automatic item_t tick_word(input logic top_sw, input logic under_sw);
    item_t w;
    w              = '0;
    w.op           = OP_TICK;
    w.top_switch   = top_sw;
    w.under_switch = under_sw;
    return w;
  endfunction

  function automatic item_t frame_word(input logic on, input logic [7:0] md,
                                       input logic [2:0] bans, input logic [7:0] gain,
                                       input logic [7:0] crit, input logic [7:0] non);
    item_t w;
    w                    = '0;
    w.op                 = OP_FRAME;
    w.control_on         = on;
    w.mode               = md;
    w.ban_mask           = bans;
    w.gain_request       = gain;
    w.critical_needed    = crit;
    w.noncritical_needed = non;
    w.top_switch         = 1'b1;
    w.under_switch       = 1'b1;
    return w;
  endfunction

  function automatic item_t edge_word(input logic [1:0] ch);
    item_t w;
    w                = '0;
    w.op             = OP_EDGE;
    w.detect_channel = ch;
    w.top_switch     = 1'b1;
    w.under_switch   = 1'b1;
    return w;
  endfunction

  // random word: every field starts as noise, the fields that matter are shaped
  // so that auto frames, hits and ticks form full trigger, drive and return cycles
  function automatic item_t random_word(input bit flood);
    item_t       w;
    logic [63:0] noise;
    int          r;
    noise = {$urandom, $urandom};
    w     = noise[$bits(item_t)-1:0];
    r     = $urandom_range(0, 99);
    if (flood) begin
      // hit-heavy traffic with thresholds mostly off, drives the counters to saturation
      if (r < 85) w.op = OP_EDGE;
      else if (r < 93) w.op = OP_FRAME;
      else w.op = OP_TICK;
    end else begin
      if (r < 45) w.op = OP_TICK;
      else if (r < 70) w.op = OP_FRAME;
      else if (r < 95) w.op = OP_EDGE;
      else w.op = OP_SPARE;
    end
    w.top_switch   = ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
    w.under_switch = ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
    case (w.op)
      OP_FRAME: begin
        if (flood) begin
          w.control_on = 1'b1;
          w.mode       = MODE_AUTO;
          w.ban_mask   = '0;
          if ($urandom_range(0, 9) != 0) begin
            w.critical_needed    = '0;
            w.noncritical_needed = '0;
          end
        end else begin
          w.control_on = ($urandom_range(0, 9) != 0);
          r = $urandom_range(0, 99);
          if (r < 55) w.mode = MODE_AUTO;
          else if (r < 65) w.mode = MODE_UP;
          else if (r < 75) w.mode = MODE_DOWN;
          if ($urandom_range(0, 9) < 7) w.ban_mask = '0;
          r = $urandom_range(0, 99);
          if (r < 70) begin
            w.critical_needed    = $urandom_range(1, 4);
            w.noncritical_needed = $urandom_range(1, 4);
          end else if (r < 85) begin
            w.critical_needed    = '0;
            w.noncritical_needed = $urandom_range(0, 3);
          end
        end
      end
      OP_EDGE: begin
        if (flood) w.detect_channel = $urandom_range(0, 1) ? CH_CRITICAL : $urandom_range(2, 3);
        else if ($urandom_range(0, 9) != 0) w.detect_channel = $urandom_range(1, 3);
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // all seven registers from one setting
  task automatic load_setting(input setting_e s);
    logic [15:0] v [7];
    case (s)
      SET_MIN:  v = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
      SET_MAX:  v = '{16'd255, 16'd255, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      SET_ZERO: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      default: begin
        v[0] = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 60);
        v[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 60);
        v[2] = $urandom_range(0, 255);
        v[3] = $urandom_range(1, 4);
        v[4] = $urandom_range(1, 25);
        v[5] = $urandom_range(1, 40);
        v[6] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(10, 200);
      end
    endcase
    write_reg(CFG_RAMP_DOWN_STEP, v[0]);
    write_reg(CFG_RAMP_UP_STEP, v[1]);
    write_reg(CFG_HOLD_LEVEL, v[2]);
    write_reg(CFG_RAMP_INTERVAL_MS, v[3]);
    write_reg(CFG_FULL_SPEED_MS, v[4]);
    write_reg(CFG_RETURN_WAIT_MS, v[5]);
    write_reg(CFG_LINK_TIMEOUT_MS, v[6]);
    cfg_we <= 1'b0;
  endtask

  // drain: every predicted word back, then a wait for the two stage pipe to settle
  task automatic wait_quiet();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    setting_e plan [9];
    item_t    w;
    int       words;

    plan = '{SET_DEFAULT, SET_MIN, SET_MAX, SET_RANDOM, SET_ZERO,
             SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};

    // every input known from time zero, reset held low
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    in_valid              = 1'b0;
    in_op                 = OP_TICK;
    in_control_on         = 1'b0;
    in_mode               = '0;
    in_ban_mask           = '0;
    in_gain_request       = '0;
    in_critical_needed    = '0;
    in_noncritical_needed = '0;
    in_detect_channel     = '0;
    in_top_switch         = 1'b1;
    in_under_switch       = 1'b1;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on reset configuration
    offer_word(tick_word(1'b1, 1'b1));
    // hit while disabled is dropped
    offer_word(edge_word(CH_CRITICAL));
    // unused word kind
    w = edge_word(CH_CRITICAL);
    w.op = OP_SPARE;
    offer_word(w);
    // enable in auto, gain above the ceiling
    offer_word(frame_word(1'b1, MODE_AUTO, 3'd0, 8'd255, 8'd1, 8'd2));
    // channel none is dropped
    offer_word(edge_word(CH_NONE));
    offer_word(edge_word(2'd2));
    offer_word(edge_word(CH_CRITICAL));
    // threshold met: report the first channel and drive down
    offer_word(frame_word(1'b1, MODE_AUTO, 3'd0, 8'd0, 8'd1, 8'd2));
    // bottom switch stops the downward move
    offer_word(tick_word(1'b0, 1'b1));
    offer_word(tick_word(1'b1, 1'b0));
    // manual up, then the top switch stops it
    offer_word(frame_word(1'b1, MODE_UP, 3'd0, 8'd10, 8'd0, 8'd0));
    offer_word(tick_word(1'b1, 1'b0));
    // manual down, repeated mode is not a new move
    offer_word(frame_word(1'b1, MODE_DOWN, 3'd0, 8'd10, 8'd0, 8'd0));
    offer_word(frame_word(1'b1, MODE_DOWN, 3'd0, 8'd10, 8'd0, 8'd0));
    offer_word(frame_word(1'b1, 8'd7, 3'd0, 8'd10, 8'd0, 8'd0));
    // all channels banned, thresholds off
    offer_word(frame_word(1'b1, MODE_AUTO, 3'd7, 8'd254, 8'd0, 8'd0));
    offer_word(edge_word(2'd3));
    offer_word(frame_word(1'b1, 8'd255, 3'd0, 8'd254, 8'd255, 8'd255));
    offer_word(frame_word(1'b1, MODE_AUTO, 3'd0, 8'd128, 8'd255, 8'd255));
    offer_word(edge_word(2'd3));
    // control off stops everything
    offer_word(frame_word(1'b0, MODE_AUTO, 3'd0, 8'd1, 8'd1, 8'd1));
    offer_word(tick_word(1'b1, 1'b1));
    // ban change clears the latched channel, banned critical channel dropped
    offer_word(frame_word(1'b1, MODE_AUTO, 3'd5, 8'd128, 8'd1, 8'd1));
    offer_word(edge_word(CH_CRITICAL));
    offer_word(edge_word(2'd2));
    // both switches pressed at once
    offer_word(tick_word(1'b0, 1'b0));

    // random phases, each on its own register setting, written while idle
    foreach (plan[p]) begin
      in_valid <= 1'b0;
      wait_quiet();
      if (plan[p] != SET_DEFAULT) load_setting(plan[p]);
      @(negedge clk);
      // long receiver hold-off while words keep coming
      hold_off_req++;
      // the max setting never loses the link, so it carries the hit flood
      words = (plan[p] == SET_MAX) ? 650 : 180;
      repeat (words) offer_word(random_word(plan[p] == SET_MAX));
    end

    in_valid <= 1'b0;
    wait_quiet();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
